/* sv/wmar_pkg.sv */
// Shared types and constants for the warm-up moving average block.
package wmar_pkg;

	localparam int ACT_W    = 2;
	localparam int RAW_W    = 16;
	localparam int SAMPLE_W = 12;
	localparam int COUNT_W  = 24;

	localparam logic [ACT_W-1:0] ACT_SAMPLE = 2'd0;
	localparam logic [ACT_W-1:0] ACT_START  = 2'd1;
	localparam logic [ACT_W-1:0] ACT_STOP   = 2'd2;

	localparam logic [COUNT_W-1:0] RUN_LENGTH_RST = 24'd1000;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic clear_run;
		logic take_sample;
		logic update;
		logic div_step;
		logic emit;
	} wmar_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic run_done;
		logic div_last;
	} wmar_status_t;

endpackage

/* sv/wmar_if.sv */
// Valid/ready channel interfaces for input and result items.
interface wmar_in_if;
	import wmar_pkg::*;

	logic                valid;
	logic                ready;
	logic [ACT_W-1:0]    action;
	logic [RAW_W-1:0]    sample_value;

	modport source (output valid, action, sample_value, input ready);
	modport sink   (input valid, action, sample_value, output ready);
endinterface

interface wmar_out_if;
	import wmar_pkg::*;

	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] filtered_value;
	logic                run_done;

	modport source (output valid, filtered_value, run_done, input ready);
	modport sink   (input valid, filtered_value, run_done, output ready);
endinterface

/* sv/wmar_datapath.sv */
// Datapath: sample ring, running sum, run counter and serial divider.
module wmar_datapath #(
	parameter int WINDOW = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [wmar_pkg::COUNT_W-1:0]      cfg_data,
	input  logic [wmar_pkg::RAW_W-1:0]        sample_value,
	input  wmar_pkg::wmar_cmd_t               cmd,
	output wmar_pkg::wmar_status_t            status,
	output logic [wmar_pkg::SAMPLE_W-1:0]     filtered_value,
	output logic                              run_done
);
	import wmar_pkg::*;

	localparam int POS_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int CNT_W  = $clog2(WINDOW + 1);
	localparam int SUM_W  = SAMPLE_W + CNT_W;
	localparam int STEP_W = $clog2(SUM_W);

	logic [SAMPLE_W-1:0] ring_mem [WINDOW];

	logic [SAMPLE_W-1:0] sample_q;
	logic [SAMPLE_W-1:0] old_q;
	logic [POS_W-1:0]    pos_q;
	logic [CNT_W-1:0]    fill_q;
	logic [SUM_W-1:0]    sum_q;
	logic [COUNT_W-1:0]  cnt_q;
	logic [COUNT_W-1:0]  run_length_q;
	logic                done_q;
	logic [SUM_W-1:0]    quo_q;
	logic [CNT_W-1:0]    rem_q;
	logic [STEP_W-1:0]   step_q;
	logic [SAMPLE_W-1:0] out_value_q;
	logic                out_done_q;

	logic                full;
	logic [SUM_W-1:0]    sum_new;
	logic [CNT_W-1:0]    fill_new;
	logic [POS_W-1:0]    pos_new;
	logic [COUNT_W-1:0]  cnt_new;
	logic                done_now;
	logic [CNT_W:0]      shifted;
	logic [CNT_W:0]      trial;
	logic                fits;
	logic [CNT_W-1:0]    rem_new;

	// Update arithmetic for one sample
	always_comb begin
		full     = (fill_q == CNT_W'(WINDOW));
		sum_new  = sum_q - (full ? SUM_W'(old_q) : '0) + SUM_W'(sample_q);
		fill_new = full ? fill_q : fill_q + CNT_W'(1);
		pos_new  = (pos_q == POS_W'(WINDOW - 1)) ? '0 : pos_q + POS_W'(1);
		cnt_new  = cnt_q + COUNT_W'(1);
		done_now = (cnt_new >= run_length_q);
	end

	// One restoring division step
	always_comb begin
		shifted = {rem_q, quo_q[SUM_W-1]};
		trial   = shifted - {1'b0, fill_q};
		fits    = (shifted >= {1'b0, fill_q});
		rem_new = fits ? trial[CNT_W-1:0] : shifted[CNT_W-1:0];
	end

	// Sample ring: read the leaving entry on accept, write the new one on update
	always_ff @(posedge clk) begin
		if (cmd.take_sample) begin
			old_q <= ring_mem[pos_q];
		end
		if (cmd.update) begin
			ring_mem[pos_q] <= sample_q;
		end
	end

	// Control state of the run and the configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			fill_q       <= '0;
			sum_q        <= '0;
			cnt_q        <= '0;
			run_length_q <= RUN_LENGTH_RST;
			step_q       <= '0;
		end else begin
			if (cfg_write) begin
				run_length_q <= cfg_data;
			end
			if (cmd.clear_run) begin
				pos_q  <= '0;
				fill_q <= '0;
				sum_q  <= '0;
				cnt_q  <= '0;
			end else if (cmd.update) begin
				pos_q  <= pos_new;
				fill_q <= fill_new;
				sum_q  <= sum_new;
				cnt_q  <= cnt_new;
				step_q <= '0;
			end else if (cmd.div_step) begin
				step_q <= step_q + STEP_W'(1);
			end
		end
	end

	// Payload registers: sample, divider and result
	always_ff @(posedge clk) begin
		if (cmd.take_sample) begin
			sample_q <= sample_value[SAMPLE_W-1:0];
		end
		if (cmd.update) begin
			quo_q  <= sum_new;
			rem_q  <= '0;
			done_q <= done_now;
		end else if (cmd.div_step) begin
			quo_q <= {quo_q[SUM_W-2:0], fits};
			rem_q <= rem_new;
		end
		if (cmd.emit) begin
			out_value_q <= quo_q[SAMPLE_W-1:0];
			out_done_q  <= done_q;
		end
	end

	assign status.run_done = done_now;
	assign status.div_last = (step_q == STEP_W'(SUM_W - 1));
	assign filtered_value  = out_value_q;
	assign run_done        = out_done_q;

endmodule

/* sv/wmar_ctrl.sv */
// Controller: item handshakes, run state and sequencing of the datapath.
module wmar_ctrl (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [wmar_pkg::ACT_W-1:0]     action,
	output logic                           out_valid,
	input  logic                           out_ready,
	output wmar_pkg::wmar_cmd_t            cmd,
	input  wmar_pkg::wmar_status_t         status
);
	import wmar_pkg::*;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_UPDATE = 2'd1;
	localparam logic [1:0] ST_DIVIDE = 2'd2;
	localparam logic [1:0] ST_EMIT   = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       running_q;
	logic       out_valid_q;
	logic       accept;
	logic       slot_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	// Decode the state into datapath commands and the next state
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (action == ACT_START) begin
						cmd.clear_run = 1'b1;
					end else if (action == ACT_SAMPLE && running_q) begin
						cmd.take_sample = 1'b1;
						state_d         = ST_UPDATE;
					end
				end
			end
			ST_UPDATE: begin
				cmd.update = 1'b1;
				state_d    = ST_DIVIDE;
			end
			ST_DIVIDE: begin
				cmd.div_step = 1'b1;
				if (status.div_last) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (slot_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Hold state, run flag and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			running_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept && action == ACT_START) begin
				running_q <= 1'b1;
			end else if (accept && action == ACT_STOP) begin
				running_q <= 1'b0;
			end else if (cmd.update && status.run_done) begin
				running_q <= 1'b0;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* sv/warmup_moving_average_run.sv */
// Top level of the warm-up moving average over a bounded sample run.
//
//   channel   dir  handshake     payload
//   in_item   in   valid/ready   action[1:0], sample_value[15:0]
//   out_item  out  valid/ready   filtered_value[11:0], run_done
//   cfg       in   cfg_write     cfg_data[23:0] (run length)
//
// A sample taken while running occupies the block through accept with ring read,
// update, one divider step per bit of the running sum, then load of the result
// register.
// Start, stop and unused action items are taken without occupying the block.
// Reset clears the run state at once; the ring needs no clearing.
// A result waiting in the output register stalls only the next sample's final
// load; input items are not taken while that load waits.
module warmup_moving_average_run #(
	parameter int WINDOW = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [wmar_pkg::COUNT_W-1:0]  cfg_data,
	wmar_in_if.sink                       in_item,
	wmar_out_if.source                    out_item
);
	import wmar_pkg::*;

	wmar_cmd_t    cmd;
	wmar_status_t status;

	wmar_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_item.valid),
		.in_ready  (in_item.ready),
		.action    (in_item.action),
		.out_valid (out_item.valid),
		.out_ready (out_item.ready),
		.cmd       (cmd),
		.status    (status)
	);

	wmar_datapath #(
		.WINDOW (WINDOW)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write      (cfg_write),
		.cfg_data       (cfg_data),
		.sample_value   (in_item.sample_value),
		.cmd            (cmd),
		.status         (status),
		.filtered_value (out_item.filtered_value),
		.run_done       (out_item.run_done)
	);

endmodule
